>>> rtl/core/rba_pkg.sv
// Shared types, widths and constants for the relative bearing pipeline.
// Used by every module under rtl/core; has no dependencies of its own.
`timescale 1ns / 1ps

package rba_pkg;

    localparam int POS_WIDTH     = 32;
    localparam int QUAT_WIDTH    = 16;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;

    // Arctangent table length; iterations beyond it are not built.
    localparam int TABLE_LEN = 24;
    localparam int NUM_CELLS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    // Normalized pair members have magnitude below 2^30, so 31 signed bits hold them.
    localparam int NORM_BITS  = 31;
    localparam int PROD_WIDTH = 2 * NORM_BITS;
    localparam int DIFF_WIDTH = POS_WIDTH + 1;
    localparam int CS_WIDTH   = 2 * QUAT_WIDTH + 1;

    // Largest right shift the normalizer may need on a PROD_WIDTH word.
    localparam int SHIFT_MAX   = PROD_WIDTH - (NORM_BITS - 1);
    localparam int SHIFT_WIDTH = $clog2(SHIFT_MAX + 1);

    localparam int CELL_SHIFT_WIDTH = $clog2(TABLE_LEN);

    // CORDIC datapath and angle accumulator width; pi is 2^31 in the accumulator.
    localparam int ACC_WIDTH   = 34;
    localparam int ANGLE_SHIFT = 32 - ANGLE_WIDTH;
    localparam int HALF_TURN_Q = 1 << (NORM_BITS - 1);

    // atan(2^-i) with pi = 2^31, rounded to nearest.
    localparam int ATAN_TABLE [TABLE_LEN] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        logic signed [POS_WIDTH-1:0]  robot_x;
        logic signed [POS_WIDTH-1:0]  robot_y;
        logic signed [QUAT_WIDTH-1:0] yaw_quat_z;
        logic signed [QUAT_WIDTH-1:0] yaw_quat_w;
        logic signed [POS_WIDTH-1:0]  goal_x;
        logic signed [POS_WIDTH-1:0]  goal_y;
    } rba_pose_t;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] bearing;
        logic                          bearing_valid;
    } rba_result_t;

    // Load enables of a two-register unit.
    typedef struct packed {
        logic first;
        logic second;
    } rba_load_t;

endpackage

>>> rtl/core/rba_front.sv
// Input stage: displacement and unnormalized yaw cosine and sine.
// Depends on rba_pkg.
`timescale 1ns / 1ps

module rba_front
    import rba_pkg::*;
(
    input  logic                         clk,
    input  logic                         load,
    input  rba_pose_t                    pose,
    output logic signed [PROD_WIDTH-1:0] dx,
    output logic signed [PROD_WIDTH-1:0] dy,
    output logic signed [PROD_WIDTH-1:0] c,
    output logic signed [PROD_WIDTH-1:0] s,
    output logic                         zero
);

    logic signed [DIFF_WIDTH-1:0]   dx_next;
    logic signed [DIFF_WIDTH-1:0]   dy_next;
    logic signed [2*QUAT_WIDTH-1:0] ww;
    logic signed [2*QUAT_WIDTH-1:0] zz;
    logic signed [2*QUAT_WIDTH-1:0] wz;
    logic signed [CS_WIDTH-1:0]     c_next;
    logic signed [CS_WIDTH-1:0]     s_next;
    logic                           zero_next;

    logic signed [DIFF_WIDTH-1:0] dx_reg;
    logic signed [DIFF_WIDTH-1:0] dy_reg;
    logic signed [CS_WIDTH-1:0]   c_reg;
    logic signed [CS_WIDTH-1:0]   s_reg;
    logic                         zero_reg;

    always_comb
    begin
        dx_next   = DIFF_WIDTH'(pose.goal_x) - DIFF_WIDTH'(pose.robot_x);
        dy_next   = DIFF_WIDTH'(pose.goal_y) - DIFF_WIDTH'(pose.robot_y);
        ww        = pose.yaw_quat_w * pose.yaw_quat_w;
        zz        = pose.yaw_quat_z * pose.yaw_quat_z;
        wz        = pose.yaw_quat_w * pose.yaw_quat_z;
        c_next    = CS_WIDTH'(ww) - CS_WIDTH'(zz);
        s_next    = {wz, 1'b0};
        zero_next = ((dx_next == '0) && (dy_next == '0)) || ((c_next == '0) && (s_next == '0));
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            c_reg    <= c_next;
            s_reg    <= s_next;
            zero_reg <= zero_next;
        end
    end

    assign dx   = PROD_WIDTH'(dx_reg);
    assign dy   = PROD_WIDTH'(dy_reg);
    assign c    = PROD_WIDTH'(c_reg);
    assign s    = PROD_WIDTH'(s_reg);
    assign zero = zero_reg;

endmodule

>>> rtl/core/rba_norm.sv
// Two-stage block normalizer for a signed pair: shift search, then the shift itself.
// Brings the larger magnitude of a nonzero pair into [2^29, 2^30). Depends on rba_pkg.
`timescale 1ns / 1ps

module rba_norm
    import rba_pkg::*;
(
    input  logic                         clk,
    input  rba_load_t                    load,
    input  logic signed [PROD_WIDTH-1:0] a,
    input  logic signed [PROD_WIDTH-1:0] b,
    output logic signed [NORM_BITS-1:0]  a_norm,
    output logic signed [NORM_BITS-1:0]  b_norm
);

    localparam logic signed [PROD_WIDTH-1:0] LIMIT =
        {{(PROD_WIDTH - NORM_BITS + 1){1'b0}}, {(NORM_BITS - 1){1'b1}}};
    localparam logic signed [PROD_WIDTH-1:0] NEG_LIMIT = -LIMIT;

    logic signed [PROD_WIDTH-1:0] sa_a;
    logic signed [PROD_WIDTH-1:0] sa_b;
    logic [SHIFT_MAX:0]           fit;
    logic [SHIFT_WIDTH-1:0]       k_sel;
    logic [NORM_BITS-1:0]         mag_a;
    logic [NORM_BITS-1:0]         mag_b;
    logic [NORM_BITS-2:0]         mag_or;
    logic [SHIFT_WIDTH-1:0]       lead;
    logic                         left_next;
    logic [SHIFT_WIDTH-1:0]       amt_next;

    logic signed [PROD_WIDTH-1:0] a_reg;
    logic signed [PROD_WIDTH-1:0] b_reg;
    logic                         left_reg;
    logic [SHIFT_WIDTH-1:0]       amt_reg;

    logic signed [PROD_WIDTH-1:0] a_shr;
    logic signed [PROD_WIDTH-1:0] b_shr;
    logic signed [NORM_BITS-1:0]  a_next;
    logic signed [NORM_BITS-1:0]  b_next;
    logic signed [NORM_BITS-1:0]  a_norm_reg;
    logic signed [NORM_BITS-1:0]  b_norm_reg;

    // Repeated floor halving equals one floor shift, so each candidate count is
    // tested on its own and the smallest one that brings both under 2^30 wins.
    always_comb
    begin
        sa_a = a;
        sa_b = b;
        for (int k = 0; k <= SHIFT_MAX; k++)
        begin
            sa_a   = a >>> k;
            sa_b   = b >>> k;
            fit[k] = (sa_a <= LIMIT) && (sa_a >= NEG_LIMIT)
                  && (sa_b <= LIMIT) && (sa_b >= NEG_LIMIT);
        end
    end

    always_comb
    begin
        k_sel = SHIFT_WIDTH'(SHIFT_MAX);
        for (int k = SHIFT_MAX; k >= 0; k--)
        begin
            if (fit[k])
            begin
                k_sel = SHIFT_WIDTH'(k);
            end
        end
    end

    // With no halving the pair already fits in NORM_BITS, and the doubling
    // count follows from the leading one of the larger magnitude.
    always_comb
    begin
        mag_a  = a[NORM_BITS-1] ? -a[NORM_BITS-1:0] : a[NORM_BITS-1:0];
        mag_b  = b[NORM_BITS-1] ? -b[NORM_BITS-1:0] : b[NORM_BITS-1:0];
        mag_or = mag_a[NORM_BITS-2:0] | mag_b[NORM_BITS-2:0];
        lead   = '0;
        for (int p = 0; p < NORM_BITS - 1; p++)
        begin
            if (mag_or[p])
            begin
                lead = SHIFT_WIDTH'(p);
            end
        end
        left_next = fit[0];
        if (!fit[0])
        begin
            amt_next = k_sel;
        end
        else if (mag_or == '0)
        begin
            amt_next = '0;
        end
        else
        begin
            amt_next = SHIFT_WIDTH'(NORM_BITS - 2) - lead;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.first)
        begin
            a_reg    <= a;
            b_reg    <= b;
            left_reg <= left_next;
            amt_reg  <= amt_next;
        end
    end

    always_comb
    begin
        a_shr = a_reg >>> amt_reg;
        b_shr = b_reg >>> amt_reg;
        if (left_reg)
        begin
            a_next = a_reg[NORM_BITS-1:0] << amt_reg;
            b_next = b_reg[NORM_BITS-1:0] << amt_reg;
        end
        else
        begin
            a_next = a_shr[NORM_BITS-1:0];
            b_next = b_shr[NORM_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.second)
        begin
            a_norm_reg <= a_next;
            b_norm_reg <= b_next;
        end
    end

    assign a_norm = a_norm_reg;
    assign b_norm = b_norm_reg;

endmodule

>>> rtl/core/rba_rotate.sv
// Rotation of the displacement into the robot frame: products, then sums.
// Depends on rba_pkg.
`timescale 1ns / 1ps

module rba_rotate
    import rba_pkg::*;
(
    input  logic                         clk,
    input  rba_load_t                    load,
    input  logic signed [NORM_BITS-1:0]  c,
    input  logic signed [NORM_BITS-1:0]  s,
    input  logic signed [NORM_BITS-1:0]  dx,
    input  logic signed [NORM_BITS-1:0]  dy,
    output logic signed [PROD_WIDTH-1:0] fwd,
    output logic signed [PROD_WIDTH-1:0] lat
);

    logic signed [PROD_WIDTH-1:0] cdx_next;
    logic signed [PROD_WIDTH-1:0] sdy_next;
    logic signed [PROD_WIDTH-1:0] cdy_next;
    logic signed [PROD_WIDTH-1:0] sdx_next;
    logic signed [PROD_WIDTH-1:0] cdx_reg;
    logic signed [PROD_WIDTH-1:0] sdy_reg;
    logic signed [PROD_WIDTH-1:0] cdy_reg;
    logic signed [PROD_WIDTH-1:0] sdx_reg;
    logic signed [PROD_WIDTH-1:0] fwd_reg;
    logic signed [PROD_WIDTH-1:0] lat_reg;

    assign cdx_next = c * dx;
    assign sdy_next = s * dy;
    assign cdy_next = c * dy;
    assign sdx_next = s * dx;

    always_ff @(posedge clk)
    begin
        if (load.first)
        begin
            cdx_reg <= cdx_next;
            sdy_reg <= sdy_next;
            cdy_reg <= cdy_next;
            sdx_reg <= sdx_next;
        end
    end

    // Each product stays below 2^60 in magnitude, so the sums fit PROD_WIDTH.
    always_ff @(posedge clk)
    begin
        if (load.second)
        begin
            fwd_reg <= cdx_reg + sdy_reg;
            lat_reg <= cdy_reg - sdx_reg;
        end
    end

    assign fwd = fwd_reg;
    assign lat = lat_reg;

endmodule

>>> rtl/core/rba_cell.sv
// One vectoring CORDIC iteration with its own pipeline register.
// Shift and arctangent step come in as constants per position. Depends on rba_pkg.
`timescale 1ns / 1ps

module rba_cell
    import rba_pkg::*;
(
    input  logic                        clk,
    input  logic                        load,
    input  logic [CELL_SHIFT_WIDTH-1:0] shift,
    input  logic signed [ACC_WIDTH-1:0] step,
    input  logic signed [ACC_WIDTH-1:0] x_in,
    input  logic signed [ACC_WIDTH-1:0] y_in,
    input  logic signed [ACC_WIDTH-1:0] z_in,
    output logic signed [ACC_WIDTH-1:0] x_out,
    output logic signed [ACC_WIDTH-1:0] y_out,
    output logic signed [ACC_WIDTH-1:0] z_out
);

    logic signed [ACC_WIDTH-1:0] xs;
    logic signed [ACC_WIDTH-1:0] ys;
    logic signed [ACC_WIDTH-1:0] x_next;
    logic signed [ACC_WIDTH-1:0] y_next;
    logic signed [ACC_WIDTH-1:0] z_next;
    logic signed [ACC_WIDTH-1:0] x_reg;
    logic signed [ACC_WIDTH-1:0] y_reg;
    logic signed [ACC_WIDTH-1:0] z_reg;

    always_comb
    begin
        xs = x_in >>> shift;
        ys = y_in >>> shift;
        if (y_in > 0)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + step;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

>>> rtl/core/relative_bearing_angle.sv
// Pipeline from an accepted pose to its result:
// one input stage, two normalizers of two stages each around a two-stage rotation,
// a quadrant fold, one cell per CORDIC iteration and the output register.
// Throughput: one transaction per cycle; each stage holds its own valid bit and a
// stage only waits when it and every stage after it are full and the output is stalled.
// Reset clears all valid bits; datapath registers are not reset.
`timescale 1ns / 1ps

module relative_bearing_angle
    import rba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pose_valid,
    output logic        pose_stall,
    input  rba_pose_t   pose,
    output logic        angle_valid,
    input  logic        angle_stall,
    output rba_result_t angle
);

    localparam int ST_FRONT = 0;
    localparam int ST_N1A   = 1;
    localparam int ST_N1B   = 2;
    localparam int ST_MUL   = 3;
    localparam int ST_ADD   = 4;
    localparam int ST_N2A   = 5;
    localparam int ST_N2B   = 6;
    localparam int ST_FOLD  = 7;
    localparam int ST_CELL0 = 8;
    localparam int ST_OUT   = ST_CELL0 + NUM_CELLS;
    localparam int NS       = ST_OUT + 1;

    localparam int ROUND_BIAS = 1 << (ANGLE_SHIFT - 1);

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] rdy;

    logic signed [PROD_WIDTH-1:0] dx;
    logic signed [PROD_WIDTH-1:0] dy;
    logic signed [PROD_WIDTH-1:0] c;
    logic signed [PROD_WIDTH-1:0] s;
    logic                         zero_front;
    logic                         zero_reg [ST_FRONT+1:ST_OUT-1];

    logic signed [NORM_BITS-1:0]  dx_n;
    logic signed [NORM_BITS-1:0]  dy_n;
    logic signed [NORM_BITS-1:0]  c_n;
    logic signed [NORM_BITS-1:0]  s_n;
    logic signed [PROD_WIDTH-1:0] fwd;
    logic signed [PROD_WIDTH-1:0] lat;
    logic signed [NORM_BITS-1:0]  fwd_n;
    logic signed [NORM_BITS-1:0]  lat_n;

    logic signed [ACC_WIDTH-1:0] fwd_x;
    logic signed [ACC_WIDTH-1:0] lat_y;
    logic signed [ACC_WIDTH-1:0] fold_x_next;
    logic signed [ACC_WIDTH-1:0] fold_y_next;
    logic signed [ACC_WIDTH-1:0] fold_z_next;
    logic signed [ACC_WIDTH-1:0] fold_x_reg;
    logic signed [ACC_WIDTH-1:0] fold_y_reg;
    logic signed [ACC_WIDTH-1:0] fold_z_reg;

    logic signed [ACC_WIDTH-1:0] cx [NUM_CELLS+1];
    logic signed [ACC_WIDTH-1:0] cy [NUM_CELLS+1];
    logic signed [ACC_WIDTH-1:0] cz [NUM_CELLS+1];

    logic signed [ACC_WIDTH-1:0] rounded;
    rba_result_t                 result_next;
    rba_result_t                 result_reg;

    // A stage may load when it is empty or when everything downstream moves.
    assign rdy[NS-1] = !valid_reg[NS-1] || !angle_stall;
    for (genvar i = 0; i < NS - 1; i++)
    begin : g_ready
        assign rdy[i] = !valid_reg[i] || rdy[i+1];
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < NS; i++)
        begin
            if (rdy[i])
            begin
                valid_next[i] = (i == 0) ? pose_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pose_stall  = !rdy[ST_FRONT];
    assign angle_valid = valid_reg[NS-1];
    assign angle       = result_reg;

    rba_front u_front (
        .clk  (clk),
        .load (rdy[ST_FRONT]),
        .pose (pose),
        .dx   (dx),
        .dy   (dy),
        .c    (c),
        .s    (s),
        .zero (zero_front)
    );

    // The zero-input flag rides alongside the datapath.
    for (genvar i = ST_FRONT + 1; i < ST_OUT; i++)
    begin : g_zero
        if (i == ST_FRONT + 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (rdy[i])
                begin
                    zero_reg[i] <= zero_front;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (rdy[i])
                begin
                    zero_reg[i] <= zero_reg[i-1];
                end
            end
        end
    end

    rba_norm u_norm_disp (
        .clk    (clk),
        .load   ('{first: rdy[ST_N1A], second: rdy[ST_N1B]}),
        .a      (dx),
        .b      (dy),
        .a_norm (dx_n),
        .b_norm (dy_n)
    );

    rba_norm u_norm_yaw (
        .clk    (clk),
        .load   ('{first: rdy[ST_N1A], second: rdy[ST_N1B]}),
        .a      (c),
        .b      (s),
        .a_norm (c_n),
        .b_norm (s_n)
    );

    rba_rotate u_rotate (
        .clk  (clk),
        .load ('{first: rdy[ST_MUL], second: rdy[ST_ADD]}),
        .c    (c_n),
        .s    (s_n),
        .dx   (dx_n),
        .dy   (dy_n),
        .fwd  (fwd),
        .lat  (lat)
    );

    rba_norm u_norm_frame (
        .clk    (clk),
        .load   ('{first: rdy[ST_N2A], second: rdy[ST_N2B]}),
        .a      (fwd),
        .b      (lat),
        .a_norm (fwd_n),
        .b_norm (lat_n)
    );

    // Vectors in the left half-plane are turned by a quarter turn first so the
    // iterations only have to cover the right half-plane.
    always_comb
    begin
        fwd_x = ACC_WIDTH'(fwd_n);
        lat_y = ACC_WIDTH'(lat_n);
        if (fwd_x < 0)
        begin
            if (lat_y >= 0)
            begin
                fold_x_next = lat_y;
                fold_y_next = -fwd_x;
                fold_z_next = ACC_WIDTH'(HALF_TURN_Q);
            end
            else
            begin
                fold_x_next = -lat_y;
                fold_y_next = fwd_x;
                fold_z_next = -ACC_WIDTH'(HALF_TURN_Q);
            end
        end
        else
        begin
            fold_x_next = fwd_x;
            fold_y_next = lat_y;
            fold_z_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_FOLD])
        begin
            fold_x_reg <= fold_x_next;
            fold_y_reg <= fold_y_next;
            fold_z_reg <= fold_z_next;
        end
    end

    assign cx[0] = fold_x_reg;
    assign cy[0] = fold_y_reg;
    assign cz[0] = fold_z_reg;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        rba_cell u_cell (
            .clk   (clk),
            .load  (rdy[ST_CELL0+i]),
            .shift (CELL_SHIFT_WIDTH'(i)),
            .step  (ACC_WIDTH'(ATAN_TABLE[i])),
            .x_in  (cx[i]),
            .y_in  (cy[i]),
            .z_in  (cz[i]),
            .x_out (cx[i+1]),
            .y_out (cy[i+1]),
            .z_out (cz[i+1])
        );
    end

    // Round half up from the pi = 2^31 scale down to ANGLE_WIDTH bits; the
    // slice wraps a full half turn to the most negative code.
    always_comb
    begin
        rounded = cz[NUM_CELLS] + ACC_WIDTH'(ROUND_BIAS);
        if (zero_reg[ST_OUT-1])
        begin
            result_next.bearing       = '0;
            result_next.bearing_valid = 1'b0;
        end
        else
        begin
            result_next.bearing       = rounded[ANGLE_SHIFT+ANGLE_WIDTH-1:ANGLE_SHIFT];
            result_next.bearing_valid = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_OUT])
        begin
            result_reg <= result_next;
        end
    end

    // The input side only waits when every stage holds a transaction.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        pose_stall |-> (&valid_reg))
    else $error("input stalled while the pipeline has a free stage");

    // A degenerate pose always comes out as a zero bearing.
    a_zero_bearing: assert property (@(posedge clk) disable iff (!rst_n)
        (angle_valid && !angle.bearing_valid) |-> (angle.bearing == '0))
    else $error("invalid bearing carries a nonzero angle");

    // Transactions in flight change only by what enters and what leaves.
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(valid_reg) == $countones($past(valid_reg))
            + ($past(pose_valid && !pose_stall) ? 1 : 0)
            - ($past(angle_valid && !angle_stall) ? 1 : 0)))
    else $error("transaction lost or duplicated inside the pipeline");

endmodule
